>>> design/assert_macros.svh
// assertion macros used by superio_config_port_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SCP_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("scp assertion failed");

// next-cycle implication, disabled during reset
`define SCP_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("scp assertion failed");

`endif

>>> design/scp_pkg.sv
`default_nettype none

package scp_pkg;

  // key bytes on the index port and the idle read byte
  localparam logic [7:0] KEY_UNLOCK = 8'h55;
  localparam logic [7:0] KEY_LOCK   = 8'hAA;
  localparam logic [7:0] READ_IDLE  = 8'hFF;

  // register indexes with side effects or reset values
  localparam logic [3:0] REG_CHIP   = 4'd0;
  localparam logic [3:0] REG_PORTS  = 4'd1;
  localparam logic [3:0] REG_SERIAL = 4'd2;
  localparam logic [3:0] REG_FDC    = 4'd3;
  localparam logic [3:0] REG_FLOPPY = 4'd5;
  localparam logic [3:0] REG_MISC   = 4'd6;
  localparam logic [3:0] REG_ID     = 4'd13;
  localparam logic [3:0] REG_REV    = 4'd14;

  // register reset values
  localparam logic [7:0] RST_CHIP   = 8'h3A;
  localparam logic [7:0] RST_PORTS  = 8'h9F;
  localparam logic [7:0] RST_SERIAL = 8'hDC;
  localparam logic [7:0] RST_FDC    = 8'h78;
  localparam logic [7:0] RST_MISC   = 8'hFF;
  localparam logic [7:0] RST_REV    = 8'h01;

  // port base addresses
  localparam logic [9:0] BASE_COM1     = 10'h3F8;
  localparam logic [9:0] BASE_COM2     = 10'h2F8;
  localparam logic [9:0] BASE_COM3_A   = 10'h338;
  localparam logic [9:0] BASE_COM4_A   = 10'h238;
  localparam logic [9:0] BASE_COM3_B   = 10'h3E8;
  localparam logic [9:0] BASE_COM4_B   = 10'h2E8;
  localparam logic [9:0] BASE_COM4_C   = 10'h2E0;
  localparam logic [9:0] BASE_COM3_D   = 10'h220;
  localparam logic [9:0] BASE_COM4_D   = 10'h228;
  localparam logic [9:0] BASE_LPT_OFF  = 10'h000;
  localparam logic [9:0] BASE_LPT_MONO = 10'h3BC;
  localparam logic [9:0] BASE_LPT1     = 10'h378;
  localparam logic [9:0] BASE_LPT2     = 10'h278;
  localparam logic [3:0] IRQ_ODD      = 4'd4;
  localparam logic [3:0] IRQ_EVEN     = 4'd3;

  // output register occupancy
  typedef enum logic {
    OCC_EMPTY,
    OCC_FULL
  } occ_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic key_shift;
    logic idx_write;
    logic reg_write;
    logic reg_read;
  } scp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic unlocked;
    logic index_ok;
  } scp_sts_t;

  typedef struct packed {
    logic       en;
    logic [9:0] base;
    logic [3:0] irq;
  } ser_map_t;

  typedef struct packed {
    logic [9:0] com3;
    logic [9:0] com4;
  } com_pair_t;

  function automatic logic [9:0] lpt_decode(input logic [1:0] sel);
    logic [9:0] b;
    case (sel)
      2'd0:    b = BASE_LPT_OFF;
      2'd1:    b = BASE_LPT_MONO;
      2'd2:    b = BASE_LPT1;
      default: b = BASE_LPT2;
    endcase
    return b;
  endfunction

  function automatic com_pair_t com_decode(input logic [1:0] sel);
    com_pair_t p;
    case (sel)
      2'd0: begin
        p.com3 = BASE_COM3_A;
        p.com4 = BASE_COM4_A;
      end
      2'd1: begin
        p.com3 = BASE_COM3_B;
        p.com4 = BASE_COM4_B;
      end
      2'd2: begin
        p.com3 = BASE_COM3_B;
        p.com4 = BASE_COM4_C;
      end
      default: begin
        p.com3 = BASE_COM3_D;
        p.com4 = BASE_COM4_D;
      end
    endcase
    return p;
  endfunction

  // disabled port keeps its old base and irq
  function automatic ser_map_t serial_decode(input ser_map_t old, input logic en,
                                             input logic [1:0] sel, input com_pair_t com);
    ser_map_t m;
    m = old;
    m.en = en;
    if (en) begin
      case (sel)
        2'd0: begin
          m.base = BASE_COM1;
          m.irq  = IRQ_ODD;
        end
        2'd1: begin
          m.base = BASE_COM2;
          m.irq  = IRQ_EVEN;
        end
        2'd2: begin
          m.base = com.com3;
          m.irq  = IRQ_ODD;
        end
        default: begin
          m.base = com.com4;
          m.irq  = IRQ_EVEN;
        end
      endcase
    end
    return m;
  endfunction

endpackage

`default_nettype wire

>>> design/scp_req_if.sv
`default_nettype none

interface scp_req_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic       port_select;
  logic [7:0] write_data;

  modport source (output valid, output mode, output port_select, output write_data,
                  input ready);
  modport sink (input valid, input mode, input port_select, input write_data,
                output ready);
endinterface

`default_nettype wire

>>> design/scp_rsp_if.sv
`default_nettype none

interface scp_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       config_mode;
  logic [9:0] lpt_base;
  logic       serial1_enable;
  logic [9:0] serial1_base;
  logic [3:0] serial1_intr;
  logic       serial2_enable;
  logic [9:0] serial2_base;
  logic [3:0] serial2_intr;
  logic       fdc_enhanced;
  logic [1:0] density_force;
  logic       drive_swap;

  modport source (output valid, output read_data, output config_mode, output lpt_base,
                  output serial1_enable, output serial1_base, output serial1_intr,
                  output serial2_enable, output serial2_base, output serial2_intr,
                  output fdc_enhanced, output density_force, output drive_swap,
                  input ready);
  modport sink (input valid, input read_data, input config_mode, input lpt_base,
                input serial1_enable, input serial1_base, input serial1_intr,
                input serial2_enable, input serial2_base, input serial2_intr,
                input fdc_enhanced, input density_force, input drive_swap,
                output ready);
endinterface

`default_nettype wire

>>> design/scp_ctrl.sv
`default_nettype none

module scp_ctrl
  import scp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_ready,
  input  wire logic       mode,
  input  wire logic       port_select,
  input  wire logic [7:0] write_data,
  output logic            rsp_valid,
  input  wire logic       rsp_ready,
  input  wire scp_sts_t   sts,
  output scp_cmd_t        cmd
);

  occ_state_t state;
  occ_state_t state_next;
  logic       accept;
  logic       is_lock;
  logic       idx_port_wr;

  // output register occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= OCC_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  // handshake and access decode
  always_comb begin
    req_ready   = (state == OCC_EMPTY) || rsp_ready;
    rsp_valid   = (state == OCC_FULL);
    accept      = req_valid && req_ready;
    is_lock     = (write_data == KEY_LOCK);
    idx_port_wr = accept && mode && !port_select;

    cmd.load      = accept;
    cmd.key_shift = idx_port_wr && (!sts.unlocked || is_lock);
    cmd.idx_write = idx_port_wr && sts.unlocked && !is_lock;
    cmd.reg_write = accept && mode && port_select && sts.unlocked && sts.index_ok;
    cmd.reg_read  = accept && !mode && port_select && sts.unlocked && sts.index_ok;

    case (state)
      OCC_EMPTY: state_next = accept ? OCC_FULL : OCC_EMPTY;
      OCC_FULL:  state_next = (accept || !rsp_ready) ? OCC_FULL : OCC_EMPTY;
      default:   state_next = OCC_EMPTY;
    endcase
  end

endmodule

`default_nettype wire

>>> design/scp_dp.sv
`default_nettype none

module scp_dp
  import scp_pkg::*;
#(
  parameter logic [7:0] DEVICE_ID = 8'd99
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire scp_cmd_t   cmd,
  input  wire logic [7:0] write_data,
  output scp_sts_t        sts,
  output logic [7:0]      read_data,
  output logic [9:0]      lpt_base,
  output ser_map_t        serial1,
  output ser_map_t        serial2,
  output logic            fdc_enhanced,
  output logic [1:0]      density_force,
  output logic            drive_swap
);

  logic [7:0] key_hist [2];
  logic [7:0] reg_index;
  logic [7:0] reg_file [16];
  com_pair_t  com;
  logic [9:0] lpt_map;
  ser_map_t   ser1;
  ser_map_t   ser2;

  logic [3:0] idx;
  logic [7:0] diff;
  logic       wr_ports;
  logic       wr_serial;
  logic [7:0] ports_new;
  logic [7:0] serial_new;
  logic       upd_lpt;
  logic       upd_com;
  logic       upd_s1;
  logic       upd_s2;
  com_pair_t  com_new;
  com_pair_t  com_use;
  ser_map_t   ser1_next;
  ser_map_t   ser2_next;

  // reset value of each register
  function automatic logic [7:0] reg_reset(input logic [3:0] i);
    logic [7:0] v;
    case (i)
      REG_CHIP:   v = RST_CHIP;
      REG_PORTS:  v = RST_PORTS;
      REG_SERIAL: v = RST_SERIAL;
      REG_FDC:    v = RST_FDC;
      REG_MISC:   v = RST_MISC;
      REG_ID:     v = DEVICE_ID;
      REG_REV:    v = RST_REV;
      default:    v = 8'h00;
    endcase
    return v;
  endfunction

  // register write decode, new values computed from the post-write registers
  always_comb begin
    idx        = reg_index[3:0];
    diff       = write_data ^ reg_file[idx];
    wr_ports   = cmd.reg_write && (idx == REG_PORTS);
    wr_serial  = cmd.reg_write && (idx == REG_SERIAL);
    ports_new  = wr_ports ? write_data : reg_file[REG_PORTS];
    serial_new = wr_serial ? write_data : reg_file[REG_SERIAL];
    upd_lpt    = wr_ports && (diff[1:0] != 2'b00);
    upd_com    = wr_ports && (diff[6:5] != 2'b00);
    upd_s1     = upd_com || (wr_serial && (diff[2:0] != 3'b000));
    upd_s2     = (upd_com && serial_new[6]) || (wr_serial && (diff[6:4] != 3'b000));
    com_new    = com_decode(ports_new[6:5]);
    com_use    = upd_com ? com_new : com;
    ser1_next  = serial_decode(ser1, serial_new[2], serial_new[1:0], com_use);
    ser2_next  = serial_decode(ser2, serial_new[6], serial_new[5:4], com_use);
  end

  // configuration state
  always_ff @(posedge clk) begin
    if (rst) begin
      key_hist[0] <= 8'h00;
      key_hist[1] <= 8'h00;
      reg_index   <= 8'h00;
      for (int i = 0; i < 16; i++) begin
        reg_file[i] <= reg_reset(4'(i));
      end
      com.com3 <= BASE_COM3_A;
      com.com4 <= BASE_COM4_A;
      lpt_map  <= BASE_LPT1;
      ser1     <= '{en: 1'b1, base: BASE_COM1, irq: IRQ_ODD};
      ser2     <= '{en: 1'b1, base: BASE_COM2, irq: IRQ_EVEN};
    end else begin
      if (cmd.key_shift) begin
        key_hist[0] <= key_hist[1];
        key_hist[1] <= write_data;
      end
      if (cmd.idx_write) begin
        reg_index <= write_data;
      end
      if (cmd.reg_write) begin
        reg_file[idx] <= write_data;
      end
      if (upd_lpt) begin
        lpt_map <= lpt_decode(ports_new[1:0]);
      end
      if (upd_com) begin
        com <= com_new;
      end
      if (upd_s1) begin
        ser1 <= ser1_next;
      end
      if (upd_s2) begin
        ser2 <= ser2_next;
      end
    end
  end

  // read word register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      read_data <= cmd.reg_read ? reg_file[idx] : READ_IDLE;
    end
  end

  always_comb begin
    sts.unlocked  = (key_hist[0] == KEY_UNLOCK) && (key_hist[1] == KEY_UNLOCK);
    sts.index_ok  = (reg_index[7:4] == 4'h0);
    lpt_base      = lpt_map;
    serial1       = ser1;
    serial2       = ser2;
    fdc_enhanced  = reg_file[REG_FDC][1];
    density_force = reg_file[REG_FLOPPY][4:3];
    drive_swap    = reg_file[REG_FLOPPY][5];
  end

endmodule

`default_nettype wire

>>> design/superio_config_port_core.sv
// Super I/O configuration port: one bus access word in, one result word out. An access
// is taken and its result word is presented in the next cycle from the output
// register, so a new access can be taken every cycle while the sink keeps ready high; the
// rate is set by that single output register stage. The result carries the read byte (0xFF
// for writes, locked reads, index-port reads and indexes above fifteen) and the port mapping
// as it stands after the access. Two 0x55 index writes unlock, 0xAA on the index port locks.
`default_nettype none

`include "assert_macros.svh"

module superio_config_port_core
  import scp_pkg::*;
#(
  parameter logic [7:0] DEVICE_ID = 8'd99
) (
  input wire logic  clk,
  input wire logic  rst,
  scp_req_if.sink   req,
  scp_rsp_if.source rsp
);

  scp_cmd_t cmd;
  scp_sts_t sts;
  ser_map_t serial1;
  ser_map_t serial2;
  logic     req_ready;
  logic     rsp_valid;

  scp_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req.valid),
    .req_ready   (req_ready),
    .mode        (req.mode),
    .port_select (req.port_select),
    .write_data  (req.write_data),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  scp_dp #(
    .DEVICE_ID (DEVICE_ID)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .write_data    (req.write_data),
    .sts           (sts),
    .read_data     (rsp.read_data),
    .lpt_base      (rsp.lpt_base),
    .serial1       (serial1),
    .serial2       (serial2),
    .fdc_enhanced  (rsp.fdc_enhanced),
    .density_force (rsp.density_force),
    .drive_swap    (rsp.drive_swap)
  );

  // port side
  assign req.ready          = req_ready;
  assign rsp.valid          = rsp_valid;
  assign rsp.config_mode    = sts.unlocked;
  assign rsp.serial1_enable = serial1.en;
  assign rsp.serial1_base   = serial1.base;
  assign rsp.serial1_intr   = serial1.irq;
  assign rsp.serial2_enable = serial2.en;
  assign rsp.serial2_base   = serial2.base;
  assign rsp.serial2_intr   = serial2.irq;

  // every accepted access yields a result word on the next cycle
  `SCP_ASSERT_NXT(a_result_follows, clk, rst, req.valid && req.ready, rsp.valid)
  // writes never return register contents
  `SCP_ASSERT_NXT(a_write_reads_idle, clk, rst, req.valid && req.ready && req.mode,
                  rsp.read_data == READ_IDLE)
  // reads leave the port mapping untouched
  `SCP_ASSERT_NXT(a_read_keeps_map, clk, rst, req.valid && req.ready && !req.mode,
                  $stable(rsp.lpt_base) && $stable(serial1) && $stable(serial2))
  // locked data writes are dropped
  `SCP_ASSERT_NXT(a_locked_data_ignored, clk, rst,
                  req.valid && req.ready && req.mode && req.port_select && !sts.unlocked,
                  $stable(serial1) && $stable(serial2) && $stable(rsp.lpt_base))

endmodule

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench
  import scp_pkg::*;
();

  localparam logic [7:0] CHIP_ID        = 8'd99;
  localparam logic       ACC_READ       = 1'b0;
  localparam logic       ACC_WRITE      = 1'b1;
  localparam logic       PORT_INDEX     = 1'b0;
  localparam logic       PORT_DATA      = 1'b1;
  localparam logic [7:0] IDX_PORTS      = {4'h0, REG_PORTS};
  localparam logic [7:0] IDX_SERIAL     = {4'h0, REG_SERIAL};
  localparam logic [7:0] IDX_FDC        = {4'h0, REG_FDC};
  localparam logic [7:0] IDX_FLOPPY     = {4'h0, REG_FLOPPY};
  localparam logic [7:0] IDX_ID         = {4'h0, REG_ID};
  localparam int         RANDOM_WORDS   = 1050;
  localparam int         HOLD_OFF_LEN   = 64;
  localparam int         STALL_LIMIT    = 2000;
  localparam int         SHOWN_ERRORS   = 10;
  localparam int         DIRECTED_WORDS = 26;

  typedef struct packed {
    logic       en;
    logic [9:0] base;
    logic [3:0] irq;
  } serial_map_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       config_mode;
    logic [9:0] lpt_base;
    logic       serial1_enable;
    logic [9:0] serial1_base;
    logic [3:0] serial1_intr;
    logic       serial2_enable;
    logic [9:0] serial2_base;
    logic [3:0] serial2_intr;
    logic       fdc_enhanced;
    logic [1:0] density_force;
    logic       drive_swap;
  } port_status_t;

  // one directed access; when fixed_rd is set the read byte is typed in
  typedef struct packed {
    logic       mode;
    logic       port;
    logic [7:0] data;
    logic       fixed_rd;
    logic [7:0] rd;
  } access_row_t;

  access_row_t directed_accesses [DIRECTED_WORDS] = '{
    '{ACC_READ,  PORT_DATA,  8'h00,      1'b1, READ_IDLE},  // locked data read
    '{ACC_WRITE, PORT_DATA,  8'h5A,      1'b1, READ_IDLE},  // locked data write is dropped
    '{ACC_WRITE, PORT_INDEX, KEY_UNLOCK, 1'b1, READ_IDLE},
    '{ACC_WRITE, PORT_INDEX, KEY_UNLOCK, 1'b1, READ_IDLE},
    '{ACC_READ,  PORT_DATA,  8'hFF,      1'b1, RST_CHIP},   // index 0 after reset
    '{ACC_WRITE, PORT_INDEX, IDX_ID,     1'b1, READ_IDLE},
    '{ACC_READ,  PORT_DATA,  8'h00,      1'b1, CHIP_ID},
    '{ACC_READ,  PORT_INDEX, 8'h00,      1'b1, READ_IDLE},  // index port never reads back
    '{ACC_WRITE, PORT_INDEX, 8'h10,      1'b1, READ_IDLE},  // index out of range
    '{ACC_WRITE, PORT_DATA,  8'h00,      1'b1, READ_IDLE},
    '{ACC_READ,  PORT_DATA,  8'h00,      1'b1, READ_IDLE},
    '{ACC_WRITE, PORT_INDEX, IDX_PORTS,  1'b0, 8'h00},
    '{ACC_WRITE, PORT_DATA,  8'h00,      1'b0, 8'h00},      // parallel port off
    '{ACC_WRITE, PORT_DATA,  8'hE3,      1'b0, 8'h00},      // lpt2 and last com3/com4 pair
    '{ACC_READ,  PORT_DATA,  8'h00,      1'b1, 8'hE3},
    '{ACC_WRITE, PORT_INDEX, IDX_SERIAL, 1'b0, 8'h00},
    '{ACC_WRITE, PORT_DATA,  8'hFF,      1'b0, 8'h00},      // both serials on com4
    '{ACC_WRITE, PORT_DATA,  8'h00,      1'b0, 8'h00},      // both serials disabled
    '{ACC_WRITE, PORT_DATA,  8'h65,      1'b0, 8'h00},
    '{ACC_WRITE, PORT_INDEX, IDX_FDC,    1'b0, 8'h00},
    '{ACC_WRITE, PORT_DATA,  8'h02,      1'b0, 8'h00},
    '{ACC_WRITE, PORT_INDEX, IDX_FLOPPY, 1'b0, 8'h00},
    '{ACC_WRITE, PORT_DATA,  8'hFF,      1'b0, 8'h00},
    '{ACC_READ,  PORT_DATA,  8'h00,      1'b1, 8'hFF},
    '{ACC_WRITE, PORT_INDEX, KEY_LOCK,   1'b0, 8'h00},
    '{ACC_READ,  PORT_DATA,  8'h00,      1'b1, READ_IDLE}
  };

  logic clk;
  logic rst;

  scp_req_if req ();
  scp_rsp_if rsp ();

  superio_config_port_core #(.DEVICE_ID(CHIP_ID)) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // shadow of the chip state
  logic [7:0]  key_older;
  logic [7:0]  key_newer;
  logic [7:0]  cur_index;
  logic [7:0]  regs [16];
  logic [9:0]  com3_shadow;
  logic [9:0]  com4_shadow;
  logic [9:0]  lpt_addr;
  serial_map_t uart1;
  serial_map_t uart2;

  port_status_t status_expected [$];
  int           words_sent = 0;
  int           results_seen = 0;
  int           error_count = 0;
  int           idle_cycles = 0;
  logic         held_off;
  wire          steady = (words_sent >= 500) && (words_sent < 700);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic is_unlocked();
    return (key_older == KEY_UNLOCK) && (key_newer == KEY_UNLOCK);
  endfunction

  function automatic void push_key(input logic [7:0] v);
    key_older = key_newer;
    key_newer = v;
  endfunction

  // a disabled port keeps its previous base and irq
  function automatic serial_map_t remap_serial(input serial_map_t old, input logic en,
                                               input logic [1:0] sel);
    serial_map_t m;
    m = old;
    m.en = en;
    if (en) begin
      case (sel)
        2'd0: begin
          m.base = BASE_COM1;
          m.irq  = IRQ_ODD;
        end
        2'd1: begin
          m.base = BASE_COM2;
          m.irq  = IRQ_EVEN;
        end
        2'd2: begin
          m.base = com3_shadow;
          m.irq  = IRQ_ODD;
        end
        default: begin
          m.base = com4_shadow;
          m.irq  = IRQ_EVEN;
        end
      endcase
    end
    return m;
  endfunction

  // data-port write: store the byte and redo the decodes whose bits moved
  function automatic void store_register(input logic [7:0] v);
    logic [7:0] flips;
    logic [3:0] ri;
    if (cur_index > 8'd15) return;
    ri = cur_index[3:0];
    flips = v ^ regs[ri];
    regs[ri] = v;
    if (ri == REG_PORTS) begin
      if (flips[1:0] != 2'b00) begin
        case (v[1:0])
          2'd0:    lpt_addr = BASE_LPT_OFF;
          2'd1:    lpt_addr = BASE_LPT_MONO;
          2'd2:    lpt_addr = BASE_LPT1;
          default: lpt_addr = BASE_LPT2;
        endcase
      end
      if (flips[6:5] != 2'b00) begin
        case (v[6:5])
          2'd0: begin
            com3_shadow = BASE_COM3_A;
            com4_shadow = BASE_COM4_A;
          end
          2'd1: begin
            com3_shadow = BASE_COM3_B;
            com4_shadow = BASE_COM4_B;
          end
          2'd2: begin
            com3_shadow = BASE_COM3_B;
            com4_shadow = BASE_COM4_C;
          end
          default: begin
            com3_shadow = BASE_COM3_D;
            com4_shadow = BASE_COM4_D;
          end
        endcase
        uart1 = remap_serial(uart1, regs[REG_SERIAL][2], regs[REG_SERIAL][1:0]);
        if (regs[REG_SERIAL][6]) uart2 = remap_serial(uart2, 1'b1, regs[REG_SERIAL][5:4]);
      end
    end else if (ri == REG_SERIAL) begin
      if (flips[2:0] != 3'b000) uart1 = remap_serial(uart1, v[2], v[1:0]);
      if (flips[6:4] != 3'b000) uart2 = remap_serial(uart2, v[6], v[5:4]);
    end
  endfunction

  // apply one bus access to the shadow state and return the result word it yields
  function automatic port_status_t apply_access(input logic m, input logic p,
                                                input logic [7:0] d);
    port_status_t s;
    s.read_data = READ_IDLE;
    if (m == ACC_WRITE) begin
      if (is_unlocked()) begin
        if (p == PORT_INDEX) begin
          if (d == KEY_LOCK) push_key(d);
          else cur_index = d;
        end else begin
          store_register(d);
        end
      end else if (p == PORT_INDEX) begin
        push_key(d);
      end
    end else if (is_unlocked() && p == PORT_DATA && cur_index <= 8'd15) begin
      s.read_data = regs[cur_index[3:0]];
    end
    s.config_mode    = is_unlocked();
    s.lpt_base       = lpt_addr;
    s.serial1_enable = uart1.en;
    s.serial1_base   = uart1.base;
    s.serial1_intr   = uart1.irq;
    s.serial2_enable = uart2.en;
    s.serial2_base   = uart2.base;
    s.serial2_intr   = uart2.irq;
    s.fdc_enhanced   = regs[REG_FDC][1];
    s.density_force  = regs[REG_FLOPPY][4:3];
    s.drive_swap     = regs[REG_FLOPPY][5];
    return s;
  endfunction

  // offer one word, wait for it to be taken, then log its expected result
  task automatic send_word(input logic m, input logic p, input logic [7:0] d,
                           input logic fixed_rd = 1'b0, input logic [7:0] rd = 8'h00);
    port_status_t want;
    if (!steady && $urandom_range(99) < 10) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.mode        <= m;
    req.port_select <= p;
    req.write_data  <= d;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    want = apply_access(m, p, d);
    if (fixed_rd) want.read_data = rd;
    status_expected.push_back(want);
    words_sent++;
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (status_expected.size() != 0) @(posedge clk);
  endtask

  // mostly unlock / select / access / lock sequences, some noise and broken keys
  task automatic run_session();
    logic [7:0] idx;
    if ($urandom_range(99) < 15) begin
      send_word(1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom_range(255)));
      return;
    end
    send_word(ACC_WRITE, PORT_INDEX, KEY_UNLOCK);
    if ($urandom_range(99) < 10) send_word(ACC_WRITE, PORT_INDEX, 8'($urandom_range(255)));
    else send_word(ACC_WRITE, PORT_INDEX, KEY_UNLOCK);
    repeat ($urandom_range(2, 10)) begin
      case ($urandom_range(9))
        0:       idx = 8'($urandom_range(16, 255));
        1:       idx = IDX_PORTS;
        2:       idx = IDX_SERIAL;
        3:       idx = IDX_FDC;
        4:       idx = IDX_FLOPPY;
        default: idx = 8'($urandom_range(15));
      endcase
      send_word(ACC_WRITE, PORT_INDEX, idx);
      repeat ($urandom_range(1, 3))
        send_word(1'($urandom_range(1)), PORT_DATA, 8'($urandom_range(255)));
    end
    if ($urandom_range(99) < 60) send_word(ACC_WRITE, PORT_INDEX, KEY_LOCK);
  endtask

  function automatic void note_error(input string what, input logic [9:0] want,
                                     input logic [9:0] got);
    error_count++;
    if (error_count <= SHOWN_ERRORS)
      $display("mismatch on %s: expected %0h, got %0h", what, want, got);
  endfunction

  // result side: random stalls plus one long hold-off
  initial begin
    held_off = 1'b0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held_off && results_seen >= 400) begin
        held_off = 1'b1;
        rsp.ready <= 1'b0;
        repeat (HOLD_OFF_LEN) @(posedge clk);
      end else begin
        rsp.ready <= steady || ($urandom_range(99) >= 10);
      end
    end
  end

  // compare each result word with the oldest expectation
  always @(posedge clk) begin
    port_status_t want;
    port_status_t got;
    if (!rst && rsp.valid && rsp.ready) begin
      results_seen <= results_seen + 1;
      got.read_data      = rsp.read_data;
      got.config_mode    = rsp.config_mode;
      got.lpt_base       = rsp.lpt_base;
      got.serial1_enable = rsp.serial1_enable;
      got.serial1_base   = rsp.serial1_base;
      got.serial1_intr   = rsp.serial1_intr;
      got.serial2_enable = rsp.serial2_enable;
      got.serial2_base   = rsp.serial2_base;
      got.serial2_intr   = rsp.serial2_intr;
      got.fdc_enhanced   = rsp.fdc_enhanced;
      got.density_force  = rsp.density_force;
      got.drive_swap     = rsp.drive_swap;
      if (status_expected.size() == 0) begin
        error_count++;
        if (error_count <= SHOWN_ERRORS) $display("result word with nothing expected");
      end else begin
        want = status_expected.pop_front();
        if (got.read_data !== want.read_data)
          note_error("read_data", 10'(want.read_data), 10'(got.read_data));
        if (got.config_mode !== want.config_mode)
          note_error("config_mode", 10'(want.config_mode), 10'(got.config_mode));
        if (got.lpt_base !== want.lpt_base)
          note_error("lpt_base", want.lpt_base, got.lpt_base);
        if (got.serial1_enable !== want.serial1_enable)
          note_error("serial1_enable", 10'(want.serial1_enable), 10'(got.serial1_enable));
        if (got.serial1_base !== want.serial1_base)
          note_error("serial1_base", want.serial1_base, got.serial1_base);
        if (got.serial1_intr !== want.serial1_intr)
          note_error("serial1_intr", 10'(want.serial1_intr), 10'(got.serial1_intr));
        if (got.serial2_enable !== want.serial2_enable)
          note_error("serial2_enable", 10'(want.serial2_enable), 10'(got.serial2_enable));
        if (got.serial2_base !== want.serial2_base)
          note_error("serial2_base", want.serial2_base, got.serial2_base);
        if (got.serial2_intr !== want.serial2_intr)
          note_error("serial2_intr", 10'(want.serial2_intr), 10'(got.serial2_intr));
        if (got.fdc_enhanced !== want.fdc_enhanced)
          note_error("fdc_enhanced", 10'(want.fdc_enhanced), 10'(got.fdc_enhanced));
        if (got.density_force !== want.density_force)
          note_error("density_force", 10'(want.density_force), 10'(got.density_force));
        if (got.drive_swap !== want.drive_swap)
          note_error("drive_swap", 10'(want.drive_swap), 10'(got.drive_swap));
      end
    end
  end

  // watchdog on cycles where no word moves on either side
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  initial begin
    rst             <= 1'b1;
    req.valid       <= 1'b0;
    req.mode        <= ACC_READ;
    req.port_select <= PORT_INDEX;
    req.write_data  <= 8'h00;

    // shadow state after reset
    key_older = 8'h00;
    key_newer = 8'h00;
    cur_index = 8'h00;
    for (int i = 0; i < 16; i++) regs[i] = 8'h00;
    regs[REG_CHIP]   = RST_CHIP;
    regs[REG_PORTS]  = RST_PORTS;
    regs[REG_SERIAL] = RST_SERIAL;
    regs[REG_FDC]    = RST_FDC;
    regs[REG_MISC]   = RST_MISC;
    regs[REG_ID]     = CHIP_ID;
    regs[REG_REV]    = RST_REV;
    com3_shadow = BASE_COM3_A;
    com4_shadow = BASE_COM4_A;
    lpt_addr    = BASE_LPT1;
    uart1       = '{en: 1'b1, base: BASE_COM1, irq: IRQ_ODD};
    uart2       = '{en: 1'b1, base: BASE_COM2, irq: IRQ_EVEN};

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed accesses, then a pause until every result word is back
    for (int i = 0; i < DIRECTED_WORDS; i++)
      send_word(directed_accesses[i].mode, directed_accesses[i].port,
                directed_accesses[i].data, directed_accesses[i].fixed_rd,
                directed_accesses[i].rd);
    wait_drained();

    while (words_sent < DIRECTED_WORDS + RANDOM_WORDS) run_session();
    wait_drained();
    repeat (8) @(posedge clk);

    if (error_count == 0 && status_expected.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
